/* rtl/bsip_pkg.sv */
// Shared types and constants of the box-sum image pyramid.
package bsip_pkg;

   localparam int NUM_LANES = 7;
   localparam int LANE_IW = $clog2(NUM_LANES);
   localparam int ACC_DEPTH = 2048;
   localparam int ACC_AW = $clog2(ACC_DEPTH);
   localparam int COORD_W = 11;
   localparam int SIZE_W = 12;
   localparam int BASE_W = 10;
   localparam int PIX_W = 8;
   localparam int FIRST_W = 22;
   localparam int PLANE_W = 20;
   localparam int LEVEL_W = 3;
   localparam int CSR_IW = 2;

   typedef enum logic [CSR_IW-1:0] {
      CSR_MERGE_MODE   = 2'd0,
      CSR_IMAGE_WIDTH  = 2'd1,
      CSR_IMAGE_HEIGHT = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_BASE  = 2'd1,
      ST_READ  = 2'd2,
      ST_WRITE = 2'd3
   } back_state_type;

   typedef struct packed {
      logic [ACC_AW-1:0]  addr;
      logic [COORD_W-1:0] bx;
      logic [COORD_W-1:0] by;
      logic               first;
      logic               last;
   } lane_op_type;

   typedef struct packed {
      logic [BASE_W-1:0]                va;
      logic [PIX_W-1:0]                 vg;
      logic [PIX_W-1:0]                 vb;
      logic [COORD_W-1:0]               x;
      logic [COORD_W-1:0]               y;
      logic                             merge;
      logic [NUM_LANES-1:0]             act;
      lane_op_type [NUM_LANES-1:0]      lane;
   } job_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [FIRST_W-1:0] a;
      logic [PLANE_W-1:0] g;
      logic [PLANE_W-1:0] b;
      logic               last;
   } result_type;

   typedef struct packed {
      logic [FIRST_W-1:0] a;
      logic [PLANE_W-1:0] g;
      logic [PLANE_W-1:0] b;
   } acc_type;

endpackage

/* rtl/bsip_queue.sv */
// Small register queue used between the pipeline parts and at the result side.
module bsip_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNTW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNTW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

/* rtl/bsip_front.sv */
// Front part: configuration, raster counters and per-level block tracking.
module bsip_front #(
   parameter int STEP = 2,
   parameter int MAX_LEVELS = 8,
   parameter int MIN_SIZE = 4,
   parameter int MAX_BLOCK_PIXELS = 4096,
   parameter int MAX_WIDTH = 2048
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [bsip_pkg::CSR_IW-1:0]        csr_index,
   input  logic [bsip_pkg::SIZE_W-1:0]        csr_data,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [bsip_pkg::PIX_W-1:0]         pixel_red,
   input  logic [bsip_pkg::PIX_W-1:0]         pixel_green,
   input  logic [bsip_pkg::PIX_W-1:0]         pixel_blue,
   input  logic                               job_full,
   output logic                               job_push,
   output bsip_pkg::job_type                  job
);
   import bsip_pkg::*;

   localparam int SIDE_MAX = STEP ** ((MAX_LEVELS > 1) ? (MAX_LEVELS - 1) : 1);
   localparam int CW = $clog2(SIDE_MAX);
   localparam int EXW = $clog2(ACC_DEPTH + SIDE_MAX + 1);
   localparam logic [SIZE_W-1:0] WLIM = SIZE_W'(MAX_WIDTH);
   localparam logic [SIZE_W-1:0] HLIM = SIZE_W'(ACC_DEPTH);

   logic                merge_mode_ff, merge_mode_in;
   logic [SIZE_W-1:0]   image_width_ff, image_width_in;
   logic [SIZE_W-1:0]   image_height_ff, image_height_in;
   logic [COORD_W-1:0]  col_ff, col_in, row_ff, row_in;
   logic [SIZE_W-1:0]   eff_w, eff_h, col_plus, row_plus;
   logic                accept, size_wr, row_wrap, frame_wrap;
   logic [MAX_LEVELS-1:0] lvl_ok;
   logic [NUM_LANES-1:0]  lane_act;
   lane_op_type [NUM_LANES-1:0] lane_ops;

   assign req_full = job_full;
   assign accept   = req_push && !job_full;
   assign size_wr  = csr_write && ((csr_index == CSR_IMAGE_WIDTH) ||
                                   (csr_index == CSR_IMAGE_HEIGHT));

   assign eff_w = (image_width_ff > WLIM) ? WLIM : image_width_ff;
   assign eff_h = (image_height_ff > HLIM) ? HLIM : image_height_ff;

   assign col_plus   = {1'b0, col_ff} + SIZE_W'(1);
   assign row_plus   = {1'b0, row_ff} + SIZE_W'(1);
   assign row_wrap   = (col_plus >= eff_w);
   assign frame_wrap = row_wrap && (row_plus >= eff_h);

   always_comb begin
      merge_mode_in   = merge_mode_ff;
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      col_in          = col_ff;
      row_in          = row_ff;
      if (csr_write && (csr_index == CSR_MERGE_MODE)) begin
         merge_mode_in = csr_data[0];
      end
      if (csr_write && (csr_index == CSR_IMAGE_WIDTH)) begin
         image_width_in = csr_data;
      end
      if (csr_write && (csr_index == CSR_IMAGE_HEIGHT)) begin
         image_height_in = csr_data;
      end
      if (size_wr) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (row_wrap) begin
            col_in = '0;
            row_in = frame_wrap ? '0 : row_plus[COORD_W-1:0];
         end else begin
            col_in = col_plus[COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         merge_mode_ff   <= 1'b0;
         image_width_ff  <= SIZE_W'(1024);
         image_height_ff <= SIZE_W'(768);
         col_ff          <= '0;
         row_ff          <= '0;
      end else begin
         merge_mode_ff   <= merge_mode_in;
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
      end
   end

   // The level conditions only get stricter as the level rises, so each
   // level's own test already equals "this and all lower levels exist".
   for (genvar i = 0; i < MAX_LEVELS; i++) begin : g_level
      localparam int THR = (MIN_SIZE + 1) * (STEP ** i);
      localparam bit BLK_OK = ((STEP ** (2 * i)) <= MAX_BLOCK_PIXELS);
      assign lvl_ok[i] = BLK_OK && ({20'd0, eff_w} >= 32'(THR)) &&
                         ({20'd0, eff_h} >= 32'(THR));
   end

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      if (i + 1 < MAX_LEVELS) begin : g_used
         localparam int SIDE = STEP ** (i + 1);
         localparam int OFF = MAX_WIDTH - MAX_WIDTH / (STEP ** i);
         localparam logic [CW-1:0]  SIDE_M1 = CW'(SIDE - 1);
         localparam logic [EXW-1:0] SIDE_X = EXW'(SIDE);

         logic [CW-1:0]      cx_ff, cx_in, cy_ff, cy_in;
         logic [COORD_W-1:0] bx_ff, bx_in, by_ff, by_in;
         logic [EXW-1:0]     ex_ff, ex_in, ey_ff, ey_in;

         always_comb begin
            cx_in = cx_ff;
            bx_in = bx_ff;
            ex_in = ex_ff;
            if (size_wr || (accept && row_wrap)) begin
               cx_in = '0;
               bx_in = '0;
               ex_in = SIDE_X;
            end else if (accept) begin
               if (cx_ff == SIDE_M1) begin
                  cx_in = '0;
                  bx_in = bx_ff + COORD_W'(1);
                  ex_in = ex_ff + SIDE_X;
               end else begin
                  cx_in = cx_ff + CW'(1);
               end
            end
         end

         always_comb begin
            cy_in = cy_ff;
            by_in = by_ff;
            ey_in = ey_ff;
            if (size_wr || (accept && frame_wrap)) begin
               cy_in = '0;
               by_in = '0;
               ey_in = SIDE_X;
            end else if (accept && row_wrap) begin
               if (cy_ff == SIDE_M1) begin
                  cy_in = '0;
                  by_in = by_ff + COORD_W'(1);
                  ey_in = ey_ff + SIDE_X;
               end else begin
                  cy_in = cy_ff + CW'(1);
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               cx_ff <= '0;
               bx_ff <= '0;
               ex_ff <= SIDE_X;
               cy_ff <= '0;
               by_ff <= '0;
               ey_ff <= SIDE_X;
            end else begin
               cx_ff <= cx_in;
               bx_ff <= bx_in;
               ex_ff <= ex_in;
               cy_ff <= cy_in;
               by_ff <= by_in;
               ey_ff <= ey_in;
            end
         end

         // The block is whole inside the frame when its far edge stays within it.
         assign lane_act[i] = lvl_ok[i+1] && (ex_ff <= EXW'(eff_w)) &&
                              (ey_ff <= EXW'(eff_h));
         assign lane_ops[i] = '{addr:  ACC_AW'(OFF) + bx_ff,
                                bx:    bx_ff,
                                by:    by_ff,
                                first: (cx_ff == '0) && (cy_ff == '0),
                                last:  (cx_ff == SIDE_M1) && (cy_ff == SIDE_M1)};
      end else begin : g_unused
         assign lane_act[i] = 1'b0;
         assign lane_ops[i] = '0;
      end
   end

   always_comb begin
      job = '0;
      job.x     = col_ff;
      job.y     = row_ff;
      job.merge = merge_mode_ff;
      job.act   = lane_act;
      job.lane  = lane_ops;
      if (merge_mode_ff) begin
         job.va = BASE_W'(pixel_red) + BASE_W'(pixel_green) + BASE_W'(pixel_blue);
      end else begin
         job.va = BASE_W'(pixel_red);
         job.vg = pixel_green;
         job.vb = pixel_blue;
      end
   end

   assign job_push = accept && lvl_ok[0];

endmodule

/* rtl/bsip_back.sv */
// Back part: level-0 result and accumulator read-modify-write per pyramid level.
module bsip_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_empty,
   output logic                  job_pop,
   input  bsip_pkg::job_type     job,
   input  logic                  out_full,
   output logic                  out_push,
   output bsip_pkg::result_type  out_data
);
   import bsip_pkg::*;

   back_state_type        state_ff, state_in;
   job_type               job_ff, job_in;
   logic [NUM_LANES-1:0]  pend_ff, pend_in, pend_clr, emit_mask, above;
   logic [LANE_IW-1:0]    cur_ff, cur_in, sel;
   acc_type               acc_mem [ACC_DEPTH];
   acc_type               rd_q, acc_wr;
   logic                  rd_en, wr_en;
   logic [ACC_AW-1:0]     rd_addr;
   lane_op_type           cur_op;

   assign cur_op = job_ff.lane[cur_ff];

   always_comb begin
      sel = '0;
      for (int j = NUM_LANES - 1; j >= 0; j--) begin
         if (pend_ff[j]) begin
            sel = LANE_IW'(j);
         end
      end
   end

   always_comb begin
      for (int j = 0; j < NUM_LANES; j++) begin
         emit_mask[j] = job_ff.act[j] && job_ff.lane[j].last;
         above[j]     = (LANE_IW'(j) > cur_ff);
         pend_clr[j]  = pend_ff[j] && (LANE_IW'(j) != cur_ff);
      end
   end

   always_comb begin
      acc_wr.a = cur_op.first ? FIRST_W'(job_ff.va) : rd_q.a + FIRST_W'(job_ff.va);
      acc_wr.g = cur_op.first ? PLANE_W'(job_ff.vg) : rd_q.g + PLANE_W'(job_ff.vg);
      acc_wr.b = cur_op.first ? PLANE_W'(job_ff.vb) : rd_q.b + PLANE_W'(job_ff.vb);
   end

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      pend_in  = pend_ff;
      cur_in   = cur_ff;
      job_pop  = 1'b0;
      out_push = 1'b0;
      out_data = '0;
      rd_en    = 1'b0;
      wr_en    = 1'b0;
      rd_addr  = job_ff.lane[sel].addr;
      case (state_ff)
         ST_IDLE: begin
            if (!job_empty) begin
               job_pop  = 1'b1;
               job_in   = job;
               pend_in  = job.act;
               state_in = ST_BASE;
            end
         end
         ST_BASE: begin
            out_data = '{level: '0, x: job_ff.x, y: job_ff.y,
                         a: FIRST_W'(job_ff.va), g: PLANE_W'(job_ff.vg),
                         b: PLANE_W'(job_ff.vb), last: (emit_mask == '0)};
            if (!out_full) begin
               out_push = 1'b1;
               if (pend_ff != '0) begin
                  state_in = ST_READ;
               end else if (!job_empty) begin
                  job_pop  = 1'b1;
                  job_in   = job;
                  pend_in  = job.act;
                  state_in = ST_BASE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            cur_in   = sel;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            out_data = '{level: LEVEL_W'(cur_ff) + LEVEL_W'(1),
                         x: cur_op.bx, y: cur_op.by, a: acc_wr.a,
                         g: job_ff.merge ? '0 : acc_wr.g,
                         b: job_ff.merge ? '0 : acc_wr.b,
                         last: ((emit_mask & above) == '0)};
            if (!(cur_op.last && out_full)) begin
               wr_en    = 1'b1;
               out_push = cur_op.last;
               pend_in  = pend_clr;
               if (pend_clr != '0) begin
                  state_in = ST_READ;
               end else if (!job_empty) begin
                  job_pop  = 1'b1;
                  job_in   = job;
                  pend_in  = job.act;
                  state_in = ST_BASE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= '0;
         cur_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         cur_ff   <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         acc_mem[cur_op.addr] <= acc_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_q <= acc_mem[rd_addr];
      end
   end

   a_write_follows_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRITE |-> $past(state_ff) == ST_READ || $past(state_ff) == ST_WRITE)
      else $error("accumulator update without a preceding read");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result pushed into a full queue");

   a_pending_subset: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> (pend_ff & ~job_ff.act) == '0)
      else $error("pending level that the pixel does not touch");

   a_pop_has_job: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> !job_empty)
      else $error("job taken from an empty queue");

endmodule

/* rtl/box_sum_image_pyramid.sv */
// Top level of the streaming box-sum image pyramid.
// Each pixel transaction pushed in raster order yields its level-0 value and
// every pyramid block sum it completes, lowest level first, with last_of_run
// set on the final result of that pixel. Throughput is set by the back end's
// accumulator memory, which has one registered read port: a pixel passes
// through one state for its level-0 result plus a read state and an add and
// write-back state for every pyramid level whose whole block it lies in.
// Inside the whole blocks of a frame a pixel lies in a block of every level
// in use. A full result queue holds the back end at the level-0 result and
// at each completed block sum. When the back end was idle, it first takes
// the job in its idle state. The front end tracks the raster position and
// the block position of each level with counters and hands one job per pixel
// through a two-entry queue, so pixels keep arriving while the back end works
// and while results wait in the two-entry result queue, until the job queue
// fills. Configuration must be written only while the block is idle; a write
// to the width or height restarts the frame. Frames too small for level 0
// produce no results, but their pixels are still counted.
module box_sum_image_pyramid #(
   parameter int STEP = 2,
   parameter int MAX_LEVELS = 8,
   parameter int MIN_SIZE = 4,
   parameter int MAX_BLOCK_PIXELS = 4096,
   parameter int MAX_WIDTH = 2048
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write,
   input  logic [bsip_pkg::CSR_IW-1:0]      csr_index,
   input  logic [bsip_pkg::SIZE_W-1:0]      csr_data,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [bsip_pkg::PIX_W-1:0]       req_pixel_red,
   input  logic [bsip_pkg::PIX_W-1:0]       req_pixel_green,
   input  logic [bsip_pkg::PIX_W-1:0]       req_pixel_blue,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [bsip_pkg::LEVEL_W-1:0]     rsp_level,
   output logic [bsip_pkg::COORD_W-1:0]     rsp_out_x,
   output logic [bsip_pkg::COORD_W-1:0]     rsp_out_y,
   output logic [bsip_pkg::FIRST_W-1:0]     rsp_sum_first,
   output logic [bsip_pkg::PLANE_W-1:0]     rsp_sum_green,
   output logic [bsip_pkg::PLANE_W-1:0]     rsp_sum_blue,
   output logic                             rsp_last_of_run
);
   import bsip_pkg::*;

   // Job queue between the front and back ends.
   logic       job_push, job_full, job_pop, job_empty;
   job_type    job_wr, job_rd;
   logic [$bits(job_type)-1:0] job_rd_bits;

   // Result queue toward the consumer.
   logic       res_push, res_full;
   result_type res_wr, res_rd;
   logic [$bits(result_type)-1:0] res_rd_bits;

   bsip_front #(
      .STEP(STEP), .MAX_LEVELS(MAX_LEVELS), .MIN_SIZE(MIN_SIZE),
      .MAX_BLOCK_PIXELS(MAX_BLOCK_PIXELS), .MAX_WIDTH(MAX_WIDTH)
   ) u_front (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_push(req_push), .req_full(req_full),
      .pixel_red(req_pixel_red), .pixel_green(req_pixel_green),
      .pixel_blue(req_pixel_blue),
      .job_full(job_full), .job_push(job_push), .job(job_wr)
   );

   bsip_queue #(.WIDTH($bits(job_type)), .DEPTH(2)) u_job_queue (
      .clock(clock), .reset(reset),
      .push(job_push), .wdata(job_wr), .full(job_full),
      .pop(job_pop), .rdata(job_rd_bits), .empty(job_empty)
   );

   assign job_rd = job_type'(job_rd_bits);

   bsip_back u_back (
      .clock(clock), .reset(reset),
      .job_empty(job_empty), .job_pop(job_pop), .job(job_rd),
      .out_full(res_full), .out_push(res_push), .out_data(res_wr)
   );

   bsip_queue #(.WIDTH($bits(result_type)), .DEPTH(2)) u_rsp_queue (
      .clock(clock), .reset(reset),
      .push(res_push), .wdata(res_wr), .full(res_full),
      .pop(rsp_pop), .rdata(res_rd_bits), .empty(rsp_empty)
   );

   assign res_rd          = result_type'(res_rd_bits);
   assign rsp_level       = res_rd.level;
   assign rsp_out_x       = res_rd.x;
   assign rsp_out_y       = res_rd.y;
   assign rsp_sum_first   = res_rd.a;
   assign rsp_sum_green   = res_rd.g;
   assign rsp_sum_blue    = res_rd.b;
   assign rsp_last_of_run = res_rd.last;

endmodule
